[hw/rtl/als_pkg.sv]
`timescale 1ns / 1ps

package als_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_NORMAL_LOW      = 3'd0;
  localparam logic [2:0] CFG_NORMAL_HIGH     = 3'd1;
  localparam logic [2:0] CFG_OPEN_THRESHOLD  = 3'd2;
  localparam logic [2:0] CFG_SHORT_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_QUALIFY_TICKS   = 3'd4;
  localparam logic [2:0] CFG_RESEND_TICKS    = 3'd5;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_CONFIRM = 2'd2;

  localparam logic [1:0] CLASS_NORMAL   = 2'd0;
  localparam logic [1:0] CLASS_ALARM    = 2'd1;
  localparam logic [1:0] CLASS_PARALLEL = 2'd2;

  localparam logic [15:0] SAMPLE_INVALID = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX      = 16'd65534;

  localparam logic [15:0] RST_NORMAL_LOW      = 16'd1380;
  localparam logic [15:0] RST_NORMAL_HIGH     = 16'd1480;
  localparam logic [15:0] RST_OPEN_THRESHOLD  = 16'd4000;
  localparam logic [15:0] RST_SHORT_THRESHOLD = 16'd20;
  localparam logic [15:0] RST_QUALIFY_TICKS   = 16'd10;
  localparam logic [7:0]  RST_RESEND_TICKS    = 8'd20;

  typedef struct packed {
    logic       report_valid;
    logic [2:0] report_channel;
    logic       report_alarm;
    logic [2:0] scan_channel;
    logic [9:0] reported_states;
  } out_beat_t;

endpackage

[hw/rtl/alarm_loop_supervisor.sv]
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | opcode, sample, sensor_index
// out_    | output    | out_valid/out_stall| report_valid, report_channel, report_alarm,
//         |           |                    | scan_channel, reported_states
// cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One beat per cycle while in_stall is low: all channel state updates at the edge that
// takes an input beat, and the result is written into a two-entry output buffer at
// that same edge, so out_valid rises the cycle after the input beat is taken.
// in_stall rises only when both buffer entries hold results not yet taken.
// Synchronous active-low reset restores register defaults and clears the supervisor state and the buffer count.

module alarm_loop_supervisor #(
  parameter int CHANNELS = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [15:0]                  in_sample,
  input  logic [2:0]                   in_sensor_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_report_valid,
  output logic [2:0]                   out_report_channel,
  output logic                         out_report_alarm,
  output logic [2:0]                   out_scan_channel,
  output logic [9:0]                   out_reported_states,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);
  import als_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  // configuration
  logic [15:0] normal_low_r, normal_high_r, open_thr_r, short_thr_r, qualify_ticks_r;
  logic [7:0]  resend_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_low_r    <= RST_NORMAL_LOW;
      normal_high_r   <= RST_NORMAL_HIGH;
      open_thr_r      <= RST_OPEN_THRESHOLD;
      short_thr_r     <= RST_SHORT_THRESHOLD;
      qualify_ticks_r <= RST_QUALIFY_TICKS;
      resend_ticks_r  <= RST_RESEND_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL_LOW:      normal_low_r    <= cfg_data;
        CFG_NORMAL_HIGH:     normal_high_r   <= cfg_data;
        CFG_OPEN_THRESHOLD:  open_thr_r      <= cfg_data;
        CFG_SHORT_THRESHOLD: short_thr_r     <= cfg_data;
        CFG_QUALIFY_TICKS:   qualify_ticks_r <= cfg_data;
        CFG_RESEND_TICKS:    resend_ticks_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // supervisor state
  logic [CH_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CH_W-1:0] last_done_r, last_done_nxt;
  logic            last_done_vld_r, last_done_vld_nxt;
  logic            timing_r, timing_nxt;
  logic [15:0]     qcount_r, qcount_nxt;
  logic [1:0]      acc_r [CHANNELS];
  logic [1:0]      acc_nxt [CHANNELS];
  logic [1:0]      rep_r [CHANNELS];
  logic [1:0]      rep_nxt [CHANNELS];
  logic [7:0]      timer_r [CHANNELS];
  logic [7:0]      timer_nxt [CHANNELS];
  logic            await_r [CHANNELS];
  logic            await_nxt [CHANNELS];
  logic            due_r [CHANNELS];
  logic            due_nxt [CHANNELS];
  logic            msg_r [CHANNELS];
  logic            msg_nxt [CHANNELS];

  logic            push, pop;
  out_beat_t       beat;

  logic            is_normal, finish;
  logic [1:0]      cls, acc_cur;
  logic            rvalid, ralarm;
  logic [31:0]     rchan_ext, scan_ext, idx_ext, packed_states;
  logic [CH_W-1:0] conf_ch;

  always_comb begin
    scan_ptr_nxt      = scan_ptr_r;
    last_done_nxt     = last_done_r;
    last_done_vld_nxt = last_done_vld_r;
    timing_nxt        = timing_r;
    qcount_nxt        = qcount_r;
    acc_nxt           = acc_r;
    rep_nxt           = rep_r;
    timer_nxt         = timer_r;
    await_nxt         = await_r;
    due_nxt           = due_r;
    msg_nxt           = msg_r;
    rvalid            = 1'b0;
    ralarm            = 1'b0;
    rchan_ext         = '0;
    finish            = 1'b0;
    idx_ext           = 32'(in_sensor_index);
    conf_ch           = idx_ext[CH_W-1:0];

    acc_cur = CLASS_NORMAL;
    for (int c = 0; c < CHANNELS; c++) begin
      if (CH_W'(c) == scan_ptr_r) acc_cur = acc_r[c];
    end

    is_normal = ((in_sample > normal_low_r) && (in_sample < normal_high_r)) ||
                (in_sample < short_thr_r);
    cls = (in_sample > open_thr_r) ? CLASS_ALARM : CLASS_PARALLEL;

    case (in_opcode)
      OP_SAMPLE: begin
        if (in_sample != SAMPLE_INVALID) begin
          if (is_normal) begin
            acc_nxt[scan_ptr_r] = CLASS_NORMAL;
            finish = 1'b1;
          end else if (cls == acc_cur) begin
            finish = 1'b1;
          end else begin
            timing_nxt = 1'b1;
            if (qcount_r > qualify_ticks_r) begin
              acc_nxt[scan_ptr_r] = cls;
              finish = 1'b1;
            end
          end
        end
        if (finish) begin
          last_done_nxt     = scan_ptr_r;
          last_done_vld_nxt = 1'b1;
          scan_ptr_nxt      = (scan_ptr_r == LAST_CH) ? '0 : scan_ptr_r + 1'b1;
          timing_nxt        = 1'b0;
          qcount_nxt        = '0;
        end
        // report stage on the last completed channel, one lane matches
        if (last_done_vld_nxt) begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (CH_W'(c) == last_done_nxt) begin
              if (acc_nxt[c] != rep_r[c]) begin
                msg_nxt[c]   = (acc_nxt[c] == CLASS_ALARM);
                await_nxt[c] = 1'b1;
                timer_nxt[c] = resend_ticks_r;
                due_nxt[c]   = 1'b0;
                rep_nxt[c]   = acc_nxt[c];
                rvalid       = 1'b1;
              end else if (await_r[c] && due_r[c]) begin
                due_nxt[c]   = 1'b0;
                timer_nxt[c] = resend_ticks_r;
                rvalid       = 1'b1;
              end
              if (rvalid) begin
                ralarm    = msg_nxt[c];
                rchan_ext = 32'(c);
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (timing_r) begin
          qcount_nxt = (qcount_r >= COUNT_MAX - 16'd1) ? COUNT_MAX : qcount_r + 16'd1;
        end else begin
          qcount_nxt = '0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
          if (timer_r[c] != 8'd0) begin
            timer_nxt[c] = timer_r[c] - 8'd1;
            if (timer_r[c] == 8'd1 && await_r[c]) due_nxt[c] = 1'b1;
          end
        end
      end
      OP_CONFIRM: begin
        if (idx_ext < 32'(CHANNELS)) await_nxt[conf_ch] = 1'b0;
      end
      default: ;
    endcase

    packed_states = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      packed_states[2*c +: 2] = rep_nxt[c];
    end
    scan_ext = 32'(scan_ptr_nxt);

    beat.report_valid    = rvalid;
    beat.report_channel  = rchan_ext[2:0];
    beat.report_alarm    = ralarm;
    beat.scan_channel    = scan_ext[2:0];
    beat.reported_states = packed_states[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_ptr_r      <= '0;
      last_done_r     <= '0;
      last_done_vld_r <= 1'b0;
      timing_r        <= 1'b0;
      qcount_r        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        acc_r[c]   <= CLASS_NORMAL;
        rep_r[c]   <= CLASS_NORMAL;
        timer_r[c] <= '0;
        await_r[c] <= 1'b0;
        due_r[c]   <= 1'b0;
        msg_r[c]   <= 1'b0;
      end
    end else if (push) begin
      scan_ptr_r      <= scan_ptr_nxt;
      last_done_r     <= last_done_nxt;
      last_done_vld_r <= last_done_vld_nxt;
      timing_r        <= timing_nxt;
      qcount_r        <= qcount_nxt;
      acc_r           <= acc_nxt;
      rep_r           <= rep_nxt;
      timer_r         <= timer_nxt;
      await_r         <= await_nxt;
      due_r           <= due_nxt;
      msg_r           <= msg_nxt;
    end
  end

  // two-entry result buffer; head is slot0
  logic [1:0] count_r;
  out_beat_t  slot0_r, slot1_r;

  assign in_stall  = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push && !pop) begin
      count_r <= count_r + 2'd1;
    end else if (pop && !push) begin
      count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count_r == 2'd0) slot0_r <= beat;
      else                 slot1_r <= beat;
    end else if (pop && !push) begin
      slot0_r <= slot1_r;
    end else if (pop && push) begin
      if (count_r == 2'd1) begin
        slot0_r <= beat;
      end else begin
        slot0_r <= slot1_r;
        slot1_r <= beat;
      end
    end
  end

  assign out_report_valid    = slot0_r.report_valid;
  assign out_report_channel  = slot0_r.report_channel;
  assign out_report_alarm    = slot0_r.report_alarm;
  assign out_scan_channel    = slot0_r.scan_channel;
  assign out_reported_states = slot0_r.reported_states;

endmodule

[hw/rtl/als_checker.sv]
`timescale 1ns / 1ps

module als_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_report_valid,
  input logic [2:0] out_report_channel,
  input logic       out_report_alarm,
  input logic [2:0] out_scan_channel,
  input logic [9:0] out_reported_states
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_valid) &&
      $stable(out_report_channel) && $stable(out_report_alarm) &&
      $stable(out_scan_channel) && $stable(out_reported_states))
    else $error("result beat changed under stall");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  // input backpressure only while a result is pending
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_report_valid |-> out_report_channel == 3'd0 && !out_report_alarm)
    else $error("report fields set without report");

  // a freed buffer slot takes a new beat: stall drops after a pop
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("stall held after result taken");

endmodule

bind alarm_loop_supervisor als_checker u_als_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_report_valid    (out_report_valid),
  .out_report_channel  (out_report_channel),
  .out_report_alarm    (out_report_alarm),
  .out_scan_channel    (out_scan_channel),
  .out_reported_states (out_reported_states)
);

[bench/alarm_loop_supervisor_test.sv]
`timescale 1ns / 1ps

module alarm_loop_supervisor_test;
  import als_pkg::*;

  localparam int CH = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 100;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {TREND_NORMAL, TREND_ALARM, TREND_PARALLEL, TREND_NOISE} trend_e;

  // Tracks loop classing and report state, and holds the status beats still owed.
  class loop_status_scoreboard;
    logic [15:0] win_low, win_high, open_lvl, short_lvl, hold_ticks;
    logic [7:0]  resend_period;
    int unsigned scan_ptr, done_ch, qual_count;
    bit          done_seen, qualifying;
    logic [1:0]  accepted [CH];
    logic [1:0]  reported [CH];
    logic [7:0]  resend_left [CH];
    bit          unconfirmed [CH];
    bit          resend_pending [CH];
    bit          alarm_msg [CH];
    out_beat_t   expected_q [$];
    int          errors;

    function new();
      win_low = RST_NORMAL_LOW;
      win_high = RST_NORMAL_HIGH;
      open_lvl = RST_OPEN_THRESHOLD;
      short_lvl = RST_SHORT_THRESHOLD;
      hold_ticks = RST_QUALIFY_TICKS;
      resend_period = RST_RESEND_TICKS;
      scan_ptr = 0;
      done_ch = 0;
      qual_count = 0;
      done_seen = 0;
      qualifying = 0;
      errors = 0;
      foreach (accepted[c]) begin
        accepted[c] = CLASS_NORMAL;
        reported[c] = CLASS_NORMAL;
        resend_left[c] = '0;
        unconfirmed[c] = 0;
        resend_pending[c] = 0;
        alarm_msg[c] = 0;
      end
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_NORMAL_LOW:      win_low = val;
        CFG_NORMAL_HIGH:     win_high = val;
        CFG_OPEN_THRESHOLD:  open_lvl = val;
        CFG_SHORT_THRESHOLD: short_lvl = val;
        CFG_QUALIFY_TICKS:   hold_ticks = val;
        CFG_RESEND_TICKS:    resend_period = val[7:0];
        default: ;
      endcase
    endfunction

    function void advance_scan();
      done_ch = scan_ptr;
      done_seen = 1;
      scan_ptr = (scan_ptr + 1 >= CH) ? 0 : scan_ptr + 1;
      qualifying = 0;
      qual_count = 0;
    endfunction

    function void class_sample(logic [15:0] s);
      logic [1:0] cls;
      int unsigned ch;
      ch = scan_ptr;
      if (s == SAMPLE_INVALID) return;
      if ((s > win_low && s < win_high) || s < short_lvl) begin
        accepted[ch] = CLASS_NORMAL;
        advance_scan();
        return;
      end
      cls = (s > open_lvl) ? CLASS_ALARM : CLASS_PARALLEL;
      if (cls == accepted[ch]) begin
        advance_scan();
      end else begin
        // scan holds here until the new class has persisted long enough
        qualifying = 1;
        if (qual_count > hold_ticks) begin
          accepted[ch] = cls;
          advance_scan();
        end
      end
    endfunction

    function void note_input(logic [1:0] op, logic [15:0] s, logic [2:0] idx);
      out_beat_t want;
      int unsigned i;
      int c;
      want = '0;
      case (op)
        OP_SAMPLE: begin
          class_sample(s);
          if (done_seen) begin
            i = done_ch;
            if (accepted[i] != reported[i]) begin
              alarm_msg[i] = (accepted[i] == CLASS_ALARM);
              unconfirmed[i] = 1;
              resend_left[i] = resend_period;
              resend_pending[i] = 0;
              reported[i] = accepted[i];
              want.report_valid = 1'b1;
            end else if (unconfirmed[i] && resend_pending[i]) begin
              resend_pending[i] = 0;
              resend_left[i] = resend_period;
              want.report_valid = 1'b1;
            end
            if (want.report_valid) begin
              want.report_channel = 3'(i);
              want.report_alarm = alarm_msg[i];
            end
          end
        end
        OP_TICK: begin
          if (qualifying) begin
            qual_count++;
            if (qual_count >= COUNT_MAX) qual_count = COUNT_MAX;
          end else begin
            qual_count = 0;
          end
          for (c = 0; c < CH; c++) begin
            if (resend_left[c] != 0) begin
              resend_left[c]--;
              if (resend_left[c] == 0 && unconfirmed[c]) resend_pending[c] = 1;
            end
          end
        end
        OP_CONFIRM: begin
          if (idx < CH) unconfirmed[idx] = 0;
        end
        default: ;
      endcase
      want.scan_channel = 3'(scan_ptr);
      for (c = 0; c < CH; c++) want.reported_states[2*c +: 2] = reported[c];
      expected_q.push_back(want);
    endfunction

    task flag(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("status beat %h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.report_valid !== want.report_valid)
        flag($sformatf("report_valid got %0d want %0d", got.report_valid, want.report_valid));
      if (got.report_channel !== want.report_channel)
        flag($sformatf("report_channel got %0d want %0d", got.report_channel,
                       want.report_channel));
      if (got.report_alarm !== want.report_alarm)
        flag($sformatf("report_alarm got %0d want %0d", got.report_alarm, want.report_alarm));
      if (got.scan_channel !== want.scan_channel)
        flag($sformatf("scan_channel got %0d want %0d", got.scan_channel, want.scan_channel));
      if (got.reported_states !== want.reported_states)
        flag($sformatf("reported_states got %h want %h", got.reported_states,
                       want.reported_states));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_SAMPLE;
  logic [15:0] in_sample = '0;
  logic [2:0]  in_sensor_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_report_valid;
  logic [2:0]  out_report_channel;
  logic        out_report_alarm;
  logic [2:0]  out_scan_channel;
  logic [9:0]  out_reported_states;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_NORMAL_LOW;
  logic [15:0] cfg_data = '0;

  loop_status_scoreboard sb;
  trend_e trend [CH];
  int     gap_pct = 0;
  int     stall_pct = 0;
  bit     hold_req = 0;
  int     hold_left = 0;
  int     cycle_count = 0;

  alarm_loop_supervisor #(.CHANNELS(CH)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_sample           (in_sample),
    .in_sensor_index     (in_sensor_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_report_valid    (out_report_valid),
    .out_report_channel  (out_report_channel),
    .out_report_alarm    (out_report_alarm),
    .out_scan_channel    (out_scan_channel),
    .out_reported_states (out_reported_states),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("alarm_loop_supervisor_test NOT OK");
      $finish;
    end
  end

  // result side: take beats, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result({out_report_valid, out_report_channel, out_report_alarm,
                       out_scan_channel, out_reported_states});
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] s, input logic [2:0] idx);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sample <= s;
    in_sensor_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(op, s, idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic apply_config(input logic [15:0] nl, input logic [15:0] nh,
                              input logic [15:0] op_lvl, input logic [15:0] sh,
                              input logic [15:0] qt, input logic [7:0] rs);
    write_reg(CFG_NORMAL_LOW, nl);
    write_reg(CFG_NORMAL_HIGH, nh);
    write_reg(CFG_OPEN_THRESHOLD, op_lvl);
    write_reg(CFG_SHORT_THRESHOLD, sh);
    write_reg(CFG_QUALIFY_TICKS, qt);
    write_reg(CFG_RESEND_TICKS, {8'd0, rs});
    cfg_we <= 1'b0;
  endtask

  function automatic trend_e pick_trend();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return TREND_NORMAL;
    if (r < 60) return TREND_ALARM;
    if (r < 85) return TREND_PARALLEL;
    return TREND_NOISE;
  endfunction

  // sample aimed at a class under the current thresholds
  function automatic logic [15:0] sample_for(trend_e t);
    int unsigned lo, hi, op_lvl, sh;
    lo = sb.win_low;
    hi = sb.win_high;
    op_lvl = sb.open_lvl;
    sh = sb.short_lvl;
    case (t)
      TREND_NORMAL: begin
        if (hi > lo + 1) return 16'($urandom_range(lo + 1, hi - 1));
        if (sh > 0) return 16'($urandom_range(0, sh - 1));
        return 16'($urandom);
      end
      TREND_ALARM: begin
        if (op_lvl < 65534) return 16'($urandom_range(op_lvl + 1, 65534));
        return 16'($urandom);
      end
      TREND_PARALLEL: return 16'($urandom_range(0, op_lvl));
      default: begin
        case ($urandom_range(0, 7))
          0: return SAMPLE_INVALID;
          1: return 16'd0;
          2: return 16'(lo);
          3: return 16'(hi);
          4: return 16'(op_lvl);
          5: return 16'(sh);
          6: return 16'(op_lvl + 1);
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  // samples follow a per-channel trend so repeats let a new class qualify
  task automatic random_item();
    int unsigned pick, ch;
    logic [15:0] s;
    logic [2:0]  idx;
    pick = $urandom_range(0, 99);
    s = 16'($urandom);
    idx = 3'($urandom);
    if (pick < 45) begin
      ch = sb.scan_ptr;
      if ($urandom_range(0, 3) == 0) trend[ch] = pick_trend();
      s = ($urandom_range(0, 4) == 0) ? sample_for(TREND_NOISE) : sample_for(trend[ch]);
      send_item(OP_SAMPLE, s, idx);
    end else if (pick < 80) begin
      send_item(OP_TICK, s, idx);
    end else if (pick < 95) begin
      if ($urandom_range(0, 6) != 0) idx = 3'($urandom_range(0, CH - 1));
      send_item(OP_CONFIRM, s, idx);
    end else begin
      send_item(OP_IGNORED, s, idx);
    end
  endtask

  task automatic run_phase(input idle_mode_e mode, input int count, input bit squeeze);
    gap_pct = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 6 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 6 : 0;
    if (squeeze) hold_req = 1;
    repeat (count) random_item();
    drain();
  endtask

  initial begin : main
    logic [15:0] nl, nh, op_lvl, sh, qt;
    logic [7:0]  rs;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_config(RST_NORMAL_LOW, RST_NORMAL_HIGH, RST_OPEN_THRESHOLD,
                 RST_SHORT_THRESHOLD, RST_QUALIFY_TICKS, RST_RESEND_TICKS);
    // before any channel completes the report stage stays quiet
    send_item(OP_SAMPLE, SAMPLE_INVALID, 3'd0);
    send_item(OP_CONFIRM, 16'd0, 3'd7);
    send_item(OP_IGNORED, 16'hFFFF, 3'd7);
    // open loop on channel 0: qualifies after enough ticks, then reports alarm
    send_item(OP_SAMPLE, 16'd5000, 3'd0);
    repeat (12) send_item(OP_TICK, 16'd0, 3'd0);
    send_item(OP_SAMPLE, 16'd65534, 3'd0);
    send_item(OP_SAMPLE, 16'd1381, 3'd0);
    send_item(OP_CONFIRM, 16'd0, 3'd0);
    send_item(OP_SAMPLE, 16'd0, 3'd0);
    // window edges are not normal: parallel, then back to normal
    send_item(OP_SAMPLE, 16'd1380, 3'd0);
    send_item(OP_SAMPLE, 16'd4000, 3'd0);
    send_item(OP_SAMPLE, 16'd1479, 3'd0);
    run_phase(IDLE_NONE, 140, 0);

    apply_config(16'd1000, 16'd2000, 16'd3000, 16'd100, 16'd2, 8'd3);
    run_phase(IDLE_SENDER, 140, 0);

    apply_config(16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 8'd1);
    run_phase(IDLE_RECEIVER, 140, 0);

    // empty window, no alarm level, nothing ever qualifies
    apply_config(16'd65535, 16'd0, 16'd65535, 16'd0, COUNT_MAX, 8'd255);
    run_phase(IDLE_BOTH, 120, 0);

    nl = 16'($urandom_range(0, 3000));
    nh = nl + 16'($urandom_range(2, 500));
    op_lvl = 16'($urandom_range(1500, 12000));
    sh = 16'($urandom_range(0, 200));
    qt = 16'($urandom_range(0, 4));
    rs = 8'($urandom_range(0, 6));
    apply_config(nl, nh, op_lvl, sh, qt, rs);
    run_phase(IDLE_NONE, 160, 1);

    // resend period of zero never arms the timer
    apply_config(16'd1200, 16'd1600, 16'd5000, 16'd65535, 16'd1, 8'd0);
    run_phase(IDLE_BOTH, 140, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("alarm_loop_supervisor_test OK");
    end else begin
      $display("alarm_loop_supervisor_test NOT OK");
    end
    $finish;
  end

endmodule
